[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CQ_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("cq checker: assertion failed");

// Next-cycle implication, off while reset is high.
`define CQ_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("cq checker: assertion failed");

// Next-cycle implication that also watches reset itself.
`define CQ_ASSERT_NEXT_ANY(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("cq checker: assertion failed");

`endif

[rtl/cq_pkg.sv]
package cq_pkg;

   localparam int CQ_DEPTH       = 8;
   localparam int WORD_W         = 32;
   localparam int IDX_W          = 3;
   localparam int CMD_FIFO_DEPTH = 2;
   localparam int RSP_FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_DUMP   = 2'd2
   } cq_req_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_EMPTY     = 2'd3
   } cq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_DUMP
   } cq_state_type;

   typedef struct packed {
      cq_req_type               op;
      logic signed [WORD_W-1:0] data;
   } cq_cmd_type;

   typedef struct packed {
      cq_status_type            status;
      logic signed [WORD_W-1:0] word;
      logic [IDX_W-1:0]         head_index;
      logic [IDX_W-1:0]         tail_index;
      logic                     last_result;
   } cq_rsp_type;

endpackage

[rtl/cq_fifo.sv]
module cq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_rd ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/cq_ram.sv]
module cq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/cq_front.sv]
module cq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_data_value,
   output cq_pkg::cq_cmd_type cmd,
   output logic               cmd_valid,
   input  logic               cmd_pop
);

   import cq_pkg::*;

   logic       keep;
   logic       cmd_empty;
   cq_cmd_type cmd_wr;

   // drop the unused request code here, the back end never sees it
   always_comb begin
      unique case (req_type) inside
         REQ_INSERT, REQ_REMOVE, REQ_DUMP: keep = 1'b1;
         default:                          keep = 1'b0;
      endcase
      cmd_wr.op   = cq_req_type'(req_type);
      cmd_wr.data = req_data_value;
   end

   cq_fifo #(
      .WIDTH ($bits(cq_cmd_type)),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && keep),
      .wr_data (cmd_wr),
      .rd_en   (cmd_pop),
      .rd_data (cmd),
      .full    (full),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

[rtl/cq_back.sv]
module cq_back #(
   parameter int DEPTH = cq_pkg::CQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  cq_pkg::cq_cmd_type cmd,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   output cq_pkg::cq_rsp_type rsp,
   output logic               rsp_push,
   input  logic               rsp_full
);

   import cq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   cq_state_type            state_ff, state_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic                    empty_ff, empty_in;
   logic [PTR_W-1:0]        dump_ptr_ff, dump_ptr_in;

   logic                    wr_en;
   logic [PTR_W-1:0]        wr_addr;
   logic                    rd_en;
   logic [PTR_W-1:0]        rd_addr;
   logic [WORD_W-1:0]       rd_data;
   logic                    q_full;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [PTR_W-1:0] p);
      return IDX_W'({{IDX_W{1'b0}}, p});
   endfunction

   assign q_full = !empty_ff && (advance(tail_ff) == head_ff);

   cq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      dump_ptr_in = dump_ptr_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = advance(tail_ff);
      rd_en       = 1'b0;
      rd_addr     = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  REQ_INSERT: begin
                     rsp_push = 1'b1;
                     if (!q_full) begin
                        wr_en = 1'b1;
                        if (empty_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b0;
                           wr_addr  = '0;
                        end else begin
                           tail_in = advance(tail_ff);
                        end
                     end
                  end
                  REQ_REMOVE: begin
                     if (empty_ff) begin
                        rsp_push = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_REMOVE;
                     end
                  end
                  REQ_DUMP: begin
                     if (empty_ff) begin
                        rsp_push = 1'b1;
                     end else begin
                        rd_en       = 1'b1;
                        dump_ptr_in = head_ff;
                        state_in    = ST_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_REMOVE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  head_in = advance(head_ff);
               end
            end
         end
         ST_DUMP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (dump_ptr_ff == tail_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next entry only once this beat is taken
                  rd_en       = 1'b1;
                  rd_addr     = advance(dump_ptr_ff);
                  dump_ptr_in = advance(dump_ptr_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result fields
   always_comb begin
      rsp.status      = STATUS_OK;
      rsp.word        = '0;
      rsp.head_index  = to_idx(head_in);
      rsp.tail_index  = to_idx(tail_in);
      rsp.last_result = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            case (cmd.op)
               REQ_INSERT: rsp.status = q_full   ? STATUS_OVERFLOW  : STATUS_OK;
               REQ_REMOVE: rsp.status = STATUS_UNDERFLOW;
               REQ_DUMP:   rsp.status = STATUS_EMPTY;
               default:    rsp.status = STATUS_OK;
            endcase
         end
         ST_REMOVE: begin
            rsp.word = rd_data;
         end
         ST_DUMP: begin
            rsp.word        = rd_data;
            rsp.last_result = (dump_ptr_ff == tail_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
         dump_ptr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         empty_ff    <= empty_in;
         dump_ptr_ff <= dump_ptr_in;
      end
   end

endmodule

[rtl/circular_queue_with_dump_core.sv]
// Circular queue of DEPTH signed 32-bit words with insert, remove and dump
// requests. Requests enter a two-beat command queue and are carried out by a
// sequencer that owns the head/tail pointers and a storage RAM with a
// single registered read port; results leave through a two-beat result queue,
// so either side may stall without blocking the other. Insert is answered
// when taken; remove and dump read the RAM, then return the word or the entries
// in order, one entry a cycle while the result queue has room. Request code
// 3 is taken and dropped without a result. Indices reported are the low three
// bits of the pointers and read zero while the queue is empty.
module circular_queue_with_dump_core #(
   parameter int DEPTH = cq_pkg::CQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_data_value,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_word_out,
   output logic [2:0]         rsp_head_index,
   output logic [2:0]         rsp_tail_index,
   output logic               rsp_last_result
);

   import cq_pkg::*;

   cq_cmd_type cmd;
   logic       cmd_valid;
   logic       cmd_pop;
   cq_rsp_type rsp_wr;
   cq_rsp_type rsp_rd;
   logic       rsp_push;
   logic       rsp_full;

   cq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_data_value (req_data_value),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   cq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_wr),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   cq_fifo #(
      .WIDTH ($bits(cq_rsp_type)),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr),
      .rd_en   (pop),
      .rd_data (rsp_rd),
      .full    (rsp_full),
      .empty   (empty)
   );

   assign rsp_status      = rsp_rd.status;
   assign rsp_word_out    = rsp_rd.word;
   assign rsp_head_index  = rsp_rd.head_index;
   assign rsp_tail_index  = rsp_rd.tail_index;
   assign rsp_last_result = rsp_rd.last_result;

endmodule

[rtl/cq_checker.sv]
`include "assert_macros.svh"

module cq_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_word_out,
   input logic [2:0]  rsp_head_index,
   input logic [2:0]  rsp_tail_index,
   input logic        rsp_last_result
);

   import cq_pkg::*;

   `CQ_ASSERT_NEXT_ANY(a_reset_clears, clock, reset, empty && !full)

   `CQ_ASSERT_IMPLY(a_error_beat_alone, clock, reset,
      !empty && rsp_status != STATUS_OK,
      rsp_word_out == '0 && rsp_last_result)

   `CQ_ASSERT_IMPLY(a_empty_indices, clock, reset,
      !empty && (rsp_status == STATUS_UNDERFLOW || rsp_status == STATUS_EMPTY),
      rsp_head_index == '0 && rsp_tail_index == '0)

   `CQ_ASSERT_NEXT(a_beat_holds, clock, reset, !empty && !pop,
      !empty && $stable(rsp_word_out) && $stable(rsp_status) && $stable(rsp_last_result))

endmodule

bind circular_queue_with_dump_core cq_checker u_cq_checker (.*);

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
   import cq_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] data;
      bit                 drain;
   } queue_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [1:0]         req_type = REQ_INSERT;
   logic signed [31:0] req_data_value = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_word_out;
   logic [2:0]         rsp_head_index;
   logic [2:0]         rsp_tail_index;
   logic               rsp_last_result;

   queue_req_type req_backlog[$];
   cq_rsp_type    owed_rsps[$];

   // shadow copy of the queue contents and pointers
   logic signed [WORD_W-1:0] q_slots[CQ_DEPTH];
   logic [IDX_W-1:0]         q_head = '0;
   logic [IDX_W-1:0]         q_tail = '0;
   bit                       q_empty = 1'b1;

   int err_count = 0;
   int reported = 0;
   int beats_in = 0;
   int beats_out = 0;

   circular_queue_with_dump_core uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_data_value (req_data_value),
      .empty          (empty),
      .pop            (pop),
      .rsp_status     (rsp_status),
      .rsp_word_out   (rsp_word_out),
      .rsp_head_index (rsp_head_index),
      .rsp_tail_index (rsp_tail_index),
      .rsp_last_result(rsp_last_result)
   );

   always #10 clock = ~clock;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == CQ_DEPTH - 1) ? '0 : i + 1'b1;
   endfunction

   task automatic owe(input cq_status_type st, input logic signed [WORD_W-1:0] w,
                      input logic last);
      cq_rsp_type r;
      r.status      = st;
      r.word        = w;
      r.head_index  = q_head;
      r.tail_index  = q_tail;
      r.last_result = last;
      owed_rsps.push_back(r);
   endtask

   task automatic apply_request(input logic [1:0] op, input logic signed [31:0] data);
      logic signed [WORD_W-1:0] w;
      logic [IDX_W-1:0]         i;
      int                       n;
      case (op)
         REQ_INSERT: begin
            if (!q_empty && next_slot(q_tail) == q_head) begin
               owe(STATUS_OVERFLOW, '0, 1'b1);
            end else begin
               if (q_empty) begin
                  q_head  = '0;
                  q_tail  = '0;
                  q_empty = 1'b0;
               end else begin
                  q_tail = next_slot(q_tail);
               end
               q_slots[q_tail] = data;
               owe(STATUS_OK, '0, 1'b1);
            end
         end
         REQ_REMOVE: begin
            if (q_empty) begin
               owe(STATUS_UNDERFLOW, '0, 1'b1);
            end else begin
               w = q_slots[q_head];
               if (q_head == q_tail) begin
                  q_head  = '0;
                  q_tail  = '0;
                  q_empty = 1'b1;
               end else begin
                  q_head = next_slot(q_head);
               end
               owe(STATUS_OK, w, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (q_empty) begin
               owe(STATUS_EMPTY, '0, 1'b1);
            end else begin
               n = (int'(q_tail) + CQ_DEPTH - int'(q_head)) % CQ_DEPTH + 1;
               i = q_head;
               for (int k = 0; k < n; k++) begin
                  owe(STATUS_OK, q_slots[i], k == n - 1);
                  i = next_slot(i);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_req(input logic [1:0] op, input logic signed [31:0] data,
                          input bit drain = 1'b0);
      queue_req_type q;
      q.op    = op;
      q.data  = data;
      q.drain = drain;
      req_backlog.push_back(q);
   endtask

   // sender
   always @(posedge clock) begin : drive
      queue_req_type nxt;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            apply_request(req_type, req_data_value);
            beats_in++;
         end
         if (push && full) begin
            // hold the beat until taken
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].drain && owed_rsps.size() != 0) &&
                      ((beats_in >= 70 && beats_in < 110) || $urandom_range(99) >= 15)) begin
            nxt = req_backlog.pop_front();
            push           <= 1'b1;
            req_type       <= nxt.op;
            req_data_value <= nxt.data;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch
      cq_rsp_type got;
      cq_rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got.status      = cq_status_type'(rsp_status);
            got.word        = rsp_word_out;
            got.head_index  = rsp_head_index;
            got.tail_index  = rsp_tail_index;
            got.last_result = rsp_last_result;
            if (owed_rsps.size() == 0) begin
               err_count++;
               if (reported < 10)
                  $display("unexpected result %0d: st=%0d word=%0d head=%0d tail=%0d last=%0d",
                           beats_out, got.status, got.word, got.head_index,
                           got.tail_index, got.last_result);
               reported++;
            end else begin
               want = owed_rsps.pop_front();
               if (got !== want) begin
                  err_count++;
                  if (reported < 10)
                     $display({"mismatch at result %0d: want st=%0d word=%0d head=%0d ",
                               "tail=%0d last=%0d, got st=%0d word=%0d head=%0d tail=%0d ",
                               "last=%0d"},
                              beats_out, want.status, want.word, want.head_index,
                              want.tail_index, want.last_result, got.status, got.word,
                              got.head_index, got.tail_index, got.last_result);
                  reported++;
               end
            end
            beats_out++;
         end
         pop <= (beats_out >= 60 && beats_out < 140) || $urandom_range(99) >= 15;
      end
   end

   initial begin
      int         counted;
      int         bias;
      int         r;
      logic [1:0] op;
      logic signed [31:0] w;

      // directed: empty-queue corner cases, extremes, fill to overflow, wrap
      add_req(REQ_REMOVE, 32'sd5);
      add_req(REQ_DUMP, -32'sd1);
      add_req(REQ_UNUSED, 32'sh5A5A_A5A5);
      add_req(REQ_INSERT, 32'sh7FFF_FFFF);
      add_req(REQ_INSERT, 32'sh8000_0000);
      add_req(REQ_INSERT, 32'sd0);
      add_req(REQ_INSERT, -32'sd1);
      add_req(REQ_DUMP, 32'sd0);
      add_req(REQ_REMOVE, 32'sd0);
      for (int k = 0; k < 5; k++)
         add_req(REQ_INSERT, $urandom);
      add_req(REQ_INSERT, 32'sh1234_5678);
      add_req(REQ_DUMP, 32'sd0);
      for (int k = 0; k < 3; k++)
         add_req(REQ_REMOVE, $urandom);
      add_req(REQ_DUMP, 32'sd0);
      add_req(REQ_UNUSED, $urandom, 1'b1);

      // random requests in stretches that are insert-heavy, balanced or remove-heavy
      counted = 0;
      bias = 50;
      for (int k = 0; counted < 110; k++) begin
         if (k % 16 == 0) begin
            case ($urandom_range(2))
               0: bias = 85;
               1: bias = 50;
               default: bias = 15;
            endcase
         end
         r = $urandom_range(99);
         if (r < 3)
            op = REQ_UNUSED;
         else if (r < 13)
            op = REQ_DUMP;
         else if ($urandom_range(99) < bias)
            op = REQ_INSERT;
         else
            op = REQ_REMOVE;
         case ($urandom_range(9))
            0: w = 32'sh7FFF_FFFF;
            1: w = 32'sh8000_0000;
            default: w = $urandom;
         endcase
         add_req(op, w, k % 45 == 44);
         if (op != REQ_UNUSED)
            counted++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || push)
         @(negedge clock);
      while (owed_rsps.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);

      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
